/* rtl/rqmks_pkg.sv */
package rqmks_pkg;

  // default table geometry
  localparam int DEPTH_DEF     = 16;
  localparam int PID_BITS_DEF  = 8;
  localparam int TIME_BITS_DEF = 16;

  // fixed field widths
  localparam int OPCODE_W = 2;
  localparam int PID_W    = 8;
  localparam int TIME_W   = 16;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int KEY_W    = 2;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_OLDEST = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_BEST   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // selection keys
  localparam logic [KEY_W-1:0] KEY_PID     = 2'd0;
  localparam logic [KEY_W-1:0] KEY_ARRIVAL = 2'd1;
  localparam logic [KEY_W-1:0] KEY_BURST   = 2'd2;
  localparam logic [KEY_W-1:0] KEY_PRIO    = 2'd3;

  localparam logic [KEY_W-1:0] KEY_SEL_RESET = KEY_BURST;

endpackage

/* rtl/rqmks_table.sv */
module rqmks_table
  import rqmks_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int WIDTH   = PID_BITS_DEF + 2 * TIME_BITS_DEF + PRIO_W,
  localparam int IDX_W  = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rqmks_cmp.sv */
module rqmks_cmp
  import rqmks_pkg::*;
#(
  parameter int PID_BITS  = PID_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [KEY_W-1:0]     key_sel,
  input  logic [PID_BITS-1:0]  a_pid,
  input  logic [TIME_BITS-1:0] a_arrival,
  input  logic [TIME_BITS-1:0] a_burst,
  input  logic [PRIO_W-1:0]    a_prio,
  input  logic [PID_BITS-1:0]  b_pid,
  input  logic [TIME_BITS-1:0] b_arrival,
  input  logic [TIME_BITS-1:0] b_burst,
  input  logic [PRIO_W-1:0]    b_prio,
  output logic                 a_better
);

  localparam int KW0 = (PID_BITS > TIME_BITS) ? PID_BITS : TIME_BITS;
  localparam int KW  = (KW0 > PRIO_W) ? KW0 : PRIO_W;

  logic [KW-1:0] ka;
  logic [KW-1:0] kb;

  always_comb begin
    unique case (key_sel)
      KEY_PID: begin
        ka = KW'(a_pid);
        kb = KW'(b_pid);
      end
      KEY_ARRIVAL: begin
        ka = KW'(a_arrival);
        kb = KW'(b_arrival);
      end
      KEY_BURST: begin
        ka = KW'(a_burst);
        kb = KW'(b_burst);
      end
      default: begin
        ka = KW'(a_prio);
        kb = KW'(b_prio);
      end
    endcase
  end

  // key, then arrival, then id; full tie is not better (earlier slot wins)
  assign a_better = (ka < kb) ||
                    ((ka == kb) && ((a_arrival < b_arrival) ||
                                    ((a_arrival == b_arrival) && (a_pid < b_pid))));

endmodule

/* rtl/ready_queue_min_key_select.sv */
// Insert, full, empty and unused opcodes: result word is loaded from the done state.
// Remove oldest scans the head slot and remove best scans every held entry; both
// then shift the entries after the chosen slot down by one before the done state.
// One table read per cycle in the scan and in the close-up shift.
// Next word is taken the cycle after a result is loaded; that result may wait.
// Reset (rst_n, synchronous): table empty, key_select = burst time; contents kept.
module ready_queue_min_key_select
  import rqmks_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PID_BITS  = PID_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [KEY_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [PID_W-1:0]    in_new_pid,
  input  logic [TIME_W-1:0]   in_new_arrival,
  input  logic [TIME_W-1:0]   in_new_burst,
  input  logic [PRIO_W-1:0]   in_new_priority,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [PID_W-1:0]    out_pid,
  output logic [COUNT_W-1:0]  out_count,
  output logic                out_is_empty
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = PID_BITS + 2 * TIME_BITS + PRIO_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_t;

  state_t                state_r, state_nxt;
  logic [OPCODE_W-1:0]   op_r, op_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      end_r, end_nxt;
  logic [IDX_W-1:0]      best_pos_r, best_pos_nxt;
  logic [PID_BITS-1:0]   best_pid_r, best_pid_nxt;
  logic [TIME_BITS-1:0]  best_arr_r, best_arr_nxt;
  logic [TIME_BITS-1:0]  best_burst_r, best_burst_nxt;
  logic [PRIO_W-1:0]     best_prio_r, best_prio_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]      rd_pos_r, rd_pos_nxt;
  logic [KEY_W-1:0]      key_sel_r, key_sel_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [PID_W-1:0]      out_pid_r, out_pid_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic                  out_is_empty_r, out_is_empty_nxt;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [ENTRY_W-1:0]    rd_data;

  logic [PID_BITS-1:0]   rd_pid;
  logic [TIME_BITS-1:0]  rd_arr;
  logic [TIME_BITS-1:0]  rd_burst;
  logic [PRIO_W-1:0]     rd_prio;
  logic                  rd_better;

  logic [PID_BITS+PID_W-1:0]   new_pid_ext;
  logic [TIME_BITS+TIME_W-1:0] new_arr_ext;
  logic [TIME_BITS+TIME_W-1:0] new_burst_ext;
  logic [ENTRY_W-1:0]          new_entry;
  logic [PID_BITS+PID_W-1:0]   best_pid_ext;
  logic [CNT_W+COUNT_W-1:0]    count_ext;
  logic                        removed;

  assign new_pid_ext   = {{PID_BITS{1'b0}}, in_new_pid};
  assign new_arr_ext   = {{TIME_BITS{1'b0}}, in_new_arrival};
  assign new_burst_ext = {{TIME_BITS{1'b0}}, in_new_burst};
  assign new_entry     = {new_pid_ext[PID_BITS-1:0], new_arr_ext[TIME_BITS-1:0],
                          new_burst_ext[TIME_BITS-1:0], in_new_priority};

  assign rd_pid   = rd_data[ENTRY_W-1 -: PID_BITS];
  assign rd_arr   = rd_data[2*TIME_BITS+PRIO_W-1 -: TIME_BITS];
  assign rd_burst = rd_data[TIME_BITS+PRIO_W-1 -: TIME_BITS];
  assign rd_prio  = rd_data[PRIO_W-1:0];

  assign best_pid_ext = {{PID_W{1'b0}}, best_pid_r};
  assign count_ext    = {{COUNT_W{1'b0}}, count_r};
  assign removed      = (res_status_r == ST_OK) && ((op_r == OP_OLDEST) || (op_r == OP_BEST));

  rqmks_table #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rqmks_cmp #(
    .PID_BITS  (PID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .key_sel   (key_sel_r),
    .a_pid     (rd_pid),
    .a_arrival (rd_arr),
    .a_burst   (rd_burst),
    .a_prio    (rd_prio),
    .b_pid     (best_pid_r),
    .b_arrival (best_arr_r),
    .b_burst   (best_burst_r),
    .b_prio    (best_prio_r),
    .a_better  (rd_better)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_pid      = out_pid_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_is_empty_r;

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    res_status_nxt   = res_status_r;
    count_nxt        = count_r;
    idx_nxt          = idx_r;
    end_nxt          = end_r;
    best_pos_nxt     = best_pos_r;
    best_pid_nxt     = best_pid_r;
    best_arr_nxt     = best_arr_r;
    best_burst_nxt   = best_burst_r;
    best_prio_nxt    = best_prio_r;
    rd_pend_nxt      = 1'b0;
    rd_pos_nxt       = rd_pos_r;
    key_sel_nxt      = cfg_wr_en ? cfg_wr_data : key_sel_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_pid_nxt      = out_pid_r;
    out_count_nxt    = out_count_r;
    out_is_empty_nxt = out_is_empty_r;
    wr_en            = 1'b0;
    wr_addr          = count_r[IDX_W-1:0];
    wr_data          = new_entry;
    rd_en            = 1'b0;
    rd_addr          = idx_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          state_nxt = S_DONE;
          unique case (in_opcode) inside
            OP_INSERT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                res_status_nxt = ST_OK;
                wr_en          = 1'b1;
                count_nxt      = count_r + 1'b1;
              end
            end
            OP_OLDEST, OP_BEST: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                res_status_nxt = ST_OK;
                idx_nxt        = '0;
                // oldest is just a scan of the head slot
                end_nxt        = (in_opcode == OP_OLDEST) ? CNT_W'(1) : count_r;
                state_nxt      = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_pend_r && ((rd_pos_r == '0) || rd_better)) begin
          best_pos_nxt   = rd_pos_r;
          best_pid_nxt   = rd_pid;
          best_arr_nxt   = rd_arr;
          best_burst_nxt = rd_burst;
          best_prio_nxt  = rd_prio;
        end
        if (idx_r != end_r) begin
          rd_en       = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_pos_nxt  = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + 1'b1;
        end else if (!rd_pend_r) begin
          idx_nxt   = CNT_W'(best_pos_r) + 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // read slot p+1, write it to slot p in the cycle after
        if (rd_pend_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_pos_r - 1'b1;
          wr_data = rd_data;
        end
        if (idx_r != count_r) begin
          rd_en       = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_pos_nxt  = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + 1'b1;
        end else if (!rd_pend_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = res_status_r;
          out_pid_nxt      = removed ? best_pid_ext[PID_W-1:0] : '0;
          out_count_nxt    = count_ext[COUNT_W-1:0];
          out_is_empty_nxt = (count_r == '0);
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      key_sel_r   <= KEY_SEL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      key_sel_r   <= key_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r           <= op_nxt;
    res_status_r   <= res_status_nxt;
    idx_r          <= idx_nxt;
    end_r          <= end_nxt;
    best_pos_r     <= best_pos_nxt;
    best_pid_r     <= best_pid_nxt;
    best_arr_r     <= best_arr_nxt;
    best_burst_r   <= best_burst_nxt;
    best_prio_r    <= best_prio_nxt;
    rd_pos_r       <= rd_pos_nxt;
    out_status_r   <= out_status_nxt;
    out_pid_r      <= out_pid_nxt;
    out_count_r    <= out_count_nxt;
    out_is_empty_r <= out_is_empty_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_IDLE || state_r == S_SHIFT))
    else $error("table write outside insert or shift");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && wr_en) |-> (CNT_W'(wr_addr) + 1'b1 < count_r))
    else $error("shift write past last held entry");

  a_fail_no_pid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_pid_r == '0))
    else $error("nonzero id on failed operation");

endmodule
